// ----- sv/disc_contact_force_accumulator_assert.svh -----
// Assertion macros shared by the contact force accumulator RTL
`ifndef DISC_CONTACT_FORCE_ACCUMULATOR_ASSERT_SVH
`define DISC_CONTACT_FORCE_ACCUMULATOR_ASSERT_SVH
// same-cycle implication
`define DCF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dcf assertion failed");
// next-cycle implication
`define DCF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dcf assertion failed");
`endif

// ----- sv/dcf_pkg.sv -----
// Package: types, constants and helpers of the contact force accumulator
`default_nettype none
package dcf_pkg;
   localparam logic [30:0] DIAM_RESET    = 31'd65536;
   localparam logic [30:0] STIFF_RESET   = 31'd655360000;
   localparam logic [30:0] DAMP_RESET    = 31'd3276800;
   localparam logic [31:0] GRAVITY_RESET = 32'd32768;

   localparam logic [7:0] CSR_DIAM    = 8'd0;
   localparam logic [7:0] CSR_STIFF   = 8'd1;
   localparam logic [7:0] CSR_DAMP    = 8'd2;
   localparam logic [7:0] CSR_GRAVITY = 8'd3;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RANGE, ST_DSQ0, ST_DSQ1, ST_DCMP, ST_SQRT, ST_DIVX, ST_DIVY,
      ST_V0, ST_V1, ST_V2, ST_V3, ST_S0, ST_S1, ST_S2,
      ST_FX0, ST_FX1, ST_FX2, ST_FX3, ST_FX4, ST_FY, ST_DONE
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
      logic signed [71:0] hi;
      logic signed [71:0] lo;
      hi = 72'sh7FFFFFFF;
      lo = -72'sh80000000;
      if (x > hi) return 32'sh7FFFFFFF;
      if (x < lo) return 32'sh80000000;
      return x[31:0];
   endfunction
endpackage
`default_nettype wire

// ----- sv/dcf_mul.sv -----
// Shared signed multiplier with registered product
`default_nettype none
module dcf_mul import dcf_pkg::*; (
   input  wire logic               clock,
   input  wire logic signed [33:0] a,
   input  wire logic signed [33:0] b,
   output logic signed [67:0]      prod_ff
);
   logic signed [67:0] prod_in;
   assign prod_in = a * b;
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule
`default_nettype wire

// ----- sv/dcf_sub.sv -----
// Shared compare and subtract unit for the square root and division steps
`default_nettype none
module dcf_sub import dcf_pkg::*; (
   input  wire logic [63:0] a,
   input  wire logic [63:0] b,
   output logic             ge,
   output logic [63:0]      diff
);
   assign ge   = (a >= b);
   assign diff = a - b;
endmodule
`default_nettype wire

// ----- sv/disc_contact_force_accumulator.sv -----
// Top level: contact force accumulator sequencer and datapath
//  channel | dir | handshake          | payload
//  req     | in  | req_tvalid/tready  | req_tdata 8 x 32b, req_tlast = last_pair
//  rsp     | out | rsp_tvalid/tready  | rsp_tdata force_x, force_y
//  csr     | in  | csr_valid/ready    | csr_index, csr_data
// A pair in contact runs 32 square root steps and two 17-step divisions on the shared
// subtract unit, plus the multiply, accumulate and control states. A pair out of range
// ends after the range check, a coincident or too distant pair after the distance
// compare.
// Reset is synchronous; sums clear and configuration registers return to defaults.
// A final result waits in the output register and the next pair is taken meanwhile;
// a later final pair holds in its last state until that register is free.
`default_nettype none
`include "disc_contact_force_accumulator_assert.svh"
module disc_contact_force_accumulator import dcf_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // own_pos_x, own_pos_y, own_vel_x, own_vel_y,
   // other_pos_x, other_pos_y, other_vel_x, other_vel_y
   input  wire logic [255:0] req_tdata,
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // force_x, force_y
   output logic [63:0]       rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [7:0]   csr_index,
   input  wire logic [31:0]  csr_data
);
   state_type state_ff, state_in;

   logic [30:0] diam_ff, stiff_ff, damp_ff;
   logic [31:0] grav_ff;

   logic signed [32:0] dx_ff, dy_ff, rvx_ff, rvy_ff, dx_in, dy_in, rvx_in, rvy_in;
   logic last_ff;
   logic signed [71:0] acc_ff, acc_in;
   logic [63:0] x_ff, x_in, r_ff, r_in, bit_ff, bit_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] dist_ff, dist_in;
   logic signed [17:0] nx_ff, nx_in, ny_ff, ny_in;
   logic signed [31:0] v_ff, v_in;
   logic signed [48:0] s_ff, s_in;
   logic signed [31:0] sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;

   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] prod_ff;
   logic signed [71:0] prod_x;
   logic [63:0] sub_a, sub_b, sub_diff;
   logic sub_ge;

   logic [32:0] magx, magy;
   logic out_of_range, skip_pair, slot_free;
   logic [32:0] rem_sh;
   logic [31:0] overlap;

   dcf_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .prod_ff(prod_ff));
   dcf_sub u_sub (.a(sub_a), .b(sub_b), .ge(sub_ge), .diff(sub_diff));

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign prod_x  = {{4{prod_ff[67]}}, prod_ff};
   assign magx    = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
   assign magy    = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
   assign out_of_range = (magx > {2'b0, diam_ff}) || (magy > {2'b0, diam_ff});
   assign skip_pair = (acc_ff[63:0] > prod_ff[63:0]) || (acc_ff[63:0] == 64'd0);
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign rem_sh  = {x_ff[31:0], bit_ff[16]};
   assign overlap = 32'({1'b0, diam_ff} - dist_ff);

   assign dx_in  = $signed({req_tdata[159], req_tdata[159:128]})
                 - $signed({req_tdata[31], req_tdata[31:0]});
   assign dy_in  = $signed({req_tdata[191], req_tdata[191:160]})
                 - $signed({req_tdata[63], req_tdata[63:32]});
   assign rvx_in = $signed({req_tdata[95], req_tdata[95:64]})
                 - $signed({req_tdata[223], req_tdata[223:192]});
   assign rvy_in = $signed({req_tdata[127], req_tdata[127:96]})
                 - $signed({req_tdata[255], req_tdata[255:224]});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_RANGE;
         ST_RANGE: state_in = out_of_range ? ST_DONE : ST_DSQ0;
         ST_DSQ0:  state_in = ST_DSQ1;
         ST_DSQ1:  state_in = ST_DCMP;
         ST_DCMP:  state_in = skip_pair ? ST_DONE : ST_SQRT;
         ST_SQRT:  if (cnt_ff == 5'd0) state_in = ST_DIVX;
         ST_DIVX:  if (cnt_ff == 5'd0) state_in = ST_DIVY;
         ST_DIVY:  if (cnt_ff == 5'd0) state_in = ST_V0;
         ST_V0:    state_in = ST_V1;
         ST_V1:    state_in = ST_V2;
         ST_V2:    state_in = ST_V3;
         ST_V3:    state_in = ST_S0;
         ST_S0:    state_in = ST_S1;
         ST_S1:    state_in = ST_S2;
         ST_S2:    state_in = ST_FX0;
         ST_FX0:   state_in = ST_FX1;
         ST_FX1:   state_in = ST_FX2;
         ST_FX2:   state_in = ST_FX3;
         ST_FX3:   state_in = ST_FX4;
         ST_FX4:   state_in = ST_FY;
         ST_FY:    state_in = ST_DONE;
         ST_DONE:  if (!last_ff || slot_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      sub_a = x_ff;
      sub_b = r_ff + bit_ff;
      acc_in = acc_ff;
      x_in = x_ff;
      r_in = r_ff;
      bit_in = bit_ff;
      cnt_in = cnt_ff;
      dist_in = dist_ff;
      nx_in = nx_ff;
      ny_in = ny_ff;
      v_in = v_ff;
      s_in = s_ff;
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_RANGE: begin
            mul_a = 34'(dx_ff);
            mul_b = 34'(dx_ff);
         end
         ST_DSQ0: begin
            acc_in = prod_x;
            mul_a = 34'(dy_ff);
            mul_b = 34'(dy_ff);
         end
         ST_DSQ1: begin
            acc_in = acc_ff + prod_x;
            mul_a = $signed({3'b0, diam_ff});
            mul_b = $signed({3'b0, diam_ff});
         end
         ST_DCMP: begin
            x_in = acc_ff[63:0];
            r_in = '0;
            bit_in = 64'h4000_0000_0000_0000;
            cnt_in = 5'd31;
         end
         ST_SQRT: begin
            if (sub_ge) begin
               x_in = sub_diff;
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               dist_in = r_in[31:0];
               x_in = {32'b0, magx[32:1]};
               r_in = '0;
               bit_in = {47'b0, magx[0], 16'b0};
               cnt_in = 5'd16;
            end
         end
         ST_DIVX, ST_DIVY: begin
            sub_a = {31'b0, rem_sh};
            sub_b = {32'b0, dist_ff};
            x_in = sub_ge ? sub_diff : {31'b0, rem_sh};
            r_in = {r_ff[62:0], sub_ge};
            bit_in = bit_ff << 1;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               if (state_ff == ST_DIVX) begin
                  nx_in = dx_ff[32] ? -$signed({1'b0, r_in[16:0]})
                                    : $signed({1'b0, r_in[16:0]});
                  x_in = {32'b0, magy[32:1]};
                  r_in = '0;
                  bit_in = {47'b0, magy[0], 16'b0};
                  cnt_in = 5'd16;
               end else begin
                  ny_in = dy_ff[32] ? -$signed({1'b0, r_in[16:0]})
                                    : $signed({1'b0, r_in[16:0]});
               end
            end
         end
         ST_V0: begin
            mul_a = 34'(rvx_ff);
            mul_b = 34'(nx_ff);
         end
         ST_V1: begin
            acc_in = prod_x;
            mul_a = 34'(rvy_ff);
            mul_b = 34'(ny_ff);
         end
         ST_V2: acc_in = acc_ff + prod_x;
         ST_V3: begin
            v_in = sat32(acc_ff >>> 16);
            mul_a = $signed({2'b0, overlap});
            mul_b = $signed({3'b0, stiff_ff});
         end
         ST_S0: begin
            acc_in = prod_x;
            mul_a = 34'(v_ff);
            mul_b = $signed({3'b0, damp_ff});
         end
         ST_S1: acc_in = acc_ff + prod_x;
         ST_S2: s_in = 49'(acc_ff >>> 16);
         ST_FX0: begin
            mul_a = 34'($signed(s_ff[48:24]));
            mul_b = 34'(nx_ff);
         end
         ST_FX1: begin
            acc_in = prod_x <<< 24;
            mul_a = $signed({10'b0, s_ff[23:0]});
            mul_b = 34'(nx_ff);
         end
         ST_FX2: begin
            acc_in = acc_ff + prod_x;
            mul_a = 34'($signed(s_ff[48:24]));
            mul_b = 34'(ny_ff);
         end
         ST_FX3: begin
            sum_x_in = sat32(72'(sum_x_ff) - (acc_ff >>> 16));
            acc_in = prod_x <<< 24;
            mul_a = $signed({10'b0, s_ff[23:0]});
            mul_b = 34'(ny_ff);
         end
         ST_FX4: acc_in = acc_ff + prod_x;
         ST_FY: sum_y_in = sat32(72'(sum_y_ff) - (acc_ff >>> 16));
         ST_DONE: begin
            if (last_ff && slot_free) begin
               rsp_data_in = {sum_y_ff, sat32(72'(sum_x_ff) + 72'($signed(grav_ff)))};
               rsp_valid_in = 1'b1;
               sum_x_in = '0;
               sum_y_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         diam_ff <= DIAM_RESET;
         stiff_ff <= STIFF_RESET;
         damp_ff <= DAMP_RESET;
         grav_ff <= GRAVITY_RESET;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_DIAM:    diam_ff <= csr_data[30:0];
               CSR_STIFF:   stiff_ff <= csr_data[30:0];
               CSR_DAMP:    damp_ff <= csr_data[30:0];
               CSR_GRAVITY: grav_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         rvx_ff <= rvx_in;
         rvy_ff <= rvy_in;
         last_ff <= req_tlast;
      end
      acc_ff <= acc_in;
      x_ff <= x_in;
      r_ff <= r_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
      dist_ff <= dist_in;
      nx_ff <= nx_in;
      ny_ff <= ny_in;
      v_ff <= v_in;
      s_ff <= s_in;
      rsp_data_ff <= rsp_data_in;
   end

   `DCF_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   `DCF_ASSERT_NOW(a_dist_in_range, state_ff == ST_DIVX, dist_ff <= {1'b0, diam_ff})
   `DCF_ASSERT_NOW(a_unit_bounded, state_ff == ST_V0,
      (nx_ff <= 18'sd65536) && (nx_ff >= -18'sd65536))
   `DCF_ASSERT_NEXT(a_sum_cleared, state_ff == ST_DONE && last_ff && slot_free,
      sum_x_ff == 32'sd0 && sum_y_ff == 32'sd0 && rsp_tvalid)
endmodule
`default_nettype wire
